/* hdl/tgard_pkg.sv */
// ---------------------------------------------------------------------------
// tgard_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ---------------------------------------------------------------------------
package tgard_pkg;

  localparam int unsigned HeaderLen   = 18;
  localparam logic [7:0]  RleType     = 8'd10;
  localparam logic [7:0]  Depth24     = 8'd24;
  localparam logic [7:0]  Depth32     = 8'd32;
  localparam logic [7:0]  CountMask   = 8'h7f;
  localparam logic [7:0]  OpaqueAlpha = 8'hff;

  // status codes of a result
  localparam logic [1:0] StatusPixel     = 2'd0;
  localparam logic [1:0] StatusBadType   = 2'd1;
  localparam logic [1:0] StatusBadDepth  = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic [1:0] status;
  } result_t;

endpackage

/* hdl/tgard_decode.sv */
// ---------------------------------------------------------------------------
// tgard_decode
// Header parser and packet/pixel decoder; one byte of update per request.
// ---------------------------------------------------------------------------
module tgard_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output logic               res_valid,
  output tgard_pkg::result_t res
);
  import tgard_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_IDSKIP, PH_PKTHDR, PH_PIXEL, PH_DONE
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [4:0]  header_index, header_index_next, hidx;
  logic [7:0]  id_bytes_left, id_bytes_left_next;
  logic [7:0]  image_type, image_type_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [2:0]  bytes_per_pixel, bytes_per_pixel_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_count, packet_count_next;
  logic [1:0]  pixel_byte_index, pixel_byte_index_next;
  logic [7:0]  pixel_bytes [4];
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  rep_raw, rep;
  logic        pixel_last;

  // current byte overrides the stored one at the index being written
  function automatic logic [7:0] pick(input logic [1:0] idx, input logic [1:0] wr,
                                      input logic [7:0] b, input logic [7:0] stored);
    pick = (idx == wr) ? b : stored;
  endfunction

  always_comb begin
    // start of file restarts the header parser
    ph   = start_of_file ? PH_HEADER : phase;
    hidx = start_of_file ? 5'd0 : header_index;

    phase_next            = ph;
    header_index_next     = hidx;
    id_bytes_left_next    = id_bytes_left;
    image_type_next       = image_type;
    image_width_next      = image_width;
    image_height_next     = image_height;
    bytes_per_pixel_next  = bytes_per_pixel;
    packet_is_run_next    = packet_is_run;
    packet_count_next     = packet_count;
    pixel_byte_index_next = pixel_byte_index;
    pixels_left_next      = pixels_left;
    res_valid             = 1'b0;
    res                   = '0;

    pixel_last = ({1'b0, pixel_byte_index} + 3'd1) >= bytes_per_pixel;
    rep_raw    = packet_is_run ? packet_count : 8'd1;
    rep        = ({24'd0, rep_raw} > pixels_left) ? pixels_left[7:0] : rep_raw;

    case (ph)
      PH_HEADER: begin
        case (hidx)
          5'd0:  id_bytes_left_next = data_byte;
          5'd2:  image_type_next = data_byte;
          5'd12: image_width_next[7:0] = data_byte;
          5'd13: image_width_next[15:8] = data_byte;
          5'd14: image_height_next[7:0] = data_byte;
          5'd15: image_height_next[15:8] = data_byte;
          5'd16: bytes_per_pixel_next = (data_byte == Depth24) ? 3'd3 :
                                        (data_byte == Depth32) ? 3'd4 : 3'd0;
          default: ;
        endcase
        header_index_next = hidx + 5'd1;
        if (hidx == 5'(HeaderLen - 1)) begin
          header_index_next = '0;
          if (image_type != RleType) begin
            phase_next       = PH_DONE;
            res_valid        = 1'b1;
            res.image_done   = 1'b1;
            res.status       = StatusBadType;
          end else if (bytes_per_pixel == 3'd0) begin
            phase_next       = PH_DONE;
            res_valid        = 1'b1;
            res.image_done   = 1'b1;
            res.status       = StatusBadDepth;
          end else begin
            pixels_left_next = {16'd0, image_width} * {16'd0, image_height};
            if (image_width == 16'd0 || image_height == 16'd0) begin
              phase_next = PH_DONE;
            end else if (id_bytes_left != 8'd0) begin
              phase_next = PH_IDSKIP;
            end else begin
              phase_next = PH_PKTHDR;
            end
          end
        end
      end
      PH_IDSKIP: begin
        id_bytes_left_next = id_bytes_left - 8'd1;
        if (id_bytes_left_next == 8'd0) begin
          phase_next = PH_PKTHDR;
        end
      end
      PH_PKTHDR: begin
        packet_is_run_next    = data_byte[7];
        packet_count_next     = (data_byte & CountMask) + 8'd1;
        pixel_byte_index_next = '0;
        phase_next            = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (!pixel_last) begin
          pixel_byte_index_next = pixel_byte_index + 2'd1;
        end else begin
          pixel_byte_index_next = '0;
          pixels_left_next      = pixels_left - {24'd0, rep};
          packet_count_next     = packet_is_run ? 8'd0 : packet_count - 8'd1;
          if (pixels_left_next == 32'd0) begin
            phase_next = PH_DONE;
          end else if (packet_count_next == 8'd0) begin
            phase_next = PH_PKTHDR;
          end
          res_valid        = 1'b1;
          res.blue         = pick(2'd0, pixel_byte_index, data_byte, pixel_bytes[0]);
          res.green        = pick(2'd1, pixel_byte_index, data_byte, pixel_bytes[1]);
          res.red          = pick(2'd2, pixel_byte_index, data_byte, pixel_bytes[2]);
          res.alpha        = (bytes_per_pixel == 3'd4) ? data_byte : OpaqueAlpha;
          res.repeat_count = rep;
          res.image_done   = (pixels_left_next == 32'd0);
          res.status       = StatusPixel;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      header_index     <= '0;
      id_bytes_left    <= '0;
      image_type       <= '0;
      image_width      <= '0;
      image_height     <= '0;
      bytes_per_pixel  <= '0;
      packet_is_run    <= 1'b0;
      packet_count     <= '0;
      pixel_byte_index <= '0;
      pixels_left      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      id_bytes_left    <= id_bytes_left_next;
      image_type       <= image_type_next;
      image_width      <= image_width_next;
      image_height     <= image_height_next;
      bytes_per_pixel  <= bytes_per_pixel_next;
      packet_is_run    <= packet_is_run_next;
      packet_count     <= packet_count_next;
      pixel_byte_index <= pixel_byte_index_next;
      pixels_left      <= pixels_left_next;
    end
  end

  // pixel byte store, no reset: every entry is written before it is read
  always_ff @(posedge clk) begin
    if (accept && ph == PH_PIXEL) begin
      pixel_bytes[pixel_byte_index] <= data_byte;
    end
  end

endmodule

/* hdl/tgard_out_stage.sv */
// ---------------------------------------------------------------------------
// tgard_out_stage
// Result register; loads a new result while the old one is being taken.
// ---------------------------------------------------------------------------
module tgard_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tgard_pkg::result_t load_res,
  input  logic               take,
  output logic               full,
  output tgard_pkg::result_t res
);
  import tgard_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

/* hdl/tga_rle_pixel_decoder_top.sv */
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA type-10 run-length truecolor decoder, one file byte per request.
// ---------------------------------------------------------------------------
// Usage:
//   Feed the image file on the s_axis channel, one byte per request, with
//   s_axis_tuser[0] set on the first header byte; that byte always restarts
//   the parser. Bytes before the first start, and all bytes after the image
//   is complete (footer), are consumed and dropped.
//   Each decoded pixel comes out on m_axis as an RGBA color with a repeat
//   count of 1 to 128; m_axis_tlast marks the run that completes the image.
//   An unsupported image type or depth yields one result with m_axis_tuser
//   set to the error code, zero color and tlast high.
// Latency and throughput:
//   One byte per cycle sustained while m_axis_tready is high. A result is
//   valid in the cycle after the byte that completes it is accepted; the
//   decode between the parser state and the result register is combinational.
// Reset and stalls:
//   rst clears the parser to idle and empties the result register. While
//   the receiver stalls a full result register, s_axis_tready drops and the
//   input holds; if the result is taken in the same cycle, a new byte is
//   still accepted.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // red, green, blue, alpha, repeat_count
  output logic        m_axis_tlast,   // image_done
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import tgard_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t dec_res;
  result_t out_res;
  logic    out_full;

  // take a new byte whenever the result register is free or being drained
  assign s_axis_tready = !out_full || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tgard_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_axis_tdata),
    .start_of_file (s_axis_tuser[0]),
    .res_valid     (res_valid),
    .res           (dec_res)
  );

  tgard_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res_valid),
    .load_res (dec_res),
    .take     (m_axis_tready),
    .full     (out_full),
    .res      (out_res)
  );

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {out_res.repeat_count, out_res.alpha, out_res.blue,
                          out_res.green, out_res.red};
  assign m_axis_tlast  = out_res.image_done;
  assign m_axis_tuser  = out_res.status;

endmodule

/* hdl/tgard_checker.sv */
// ---------------------------------------------------------------------------
// tgard_checker
// Port-level checks on the decoder's result stream.
// ---------------------------------------------------------------------------
module tgard_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);
  import tgard_pkg::*;

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // error result ends the image and carries no color
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != StatusPixel |->
      m_axis_tlast && m_axis_tdata == 40'd0 &&
      (m_axis_tuser == StatusBadType || m_axis_tuser == StatusBadDepth))
    else $error("bad error result");

  // pixel run has a count of 1 to 128
  a_rep: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == StatusPixel |->
      m_axis_tdata[39:32] != 8'd0 && m_axis_tdata[39:32] <= 8'd128)
    else $error("repeat count out of range");

  // a new result only follows an accepted byte
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without input");

endmodule

bind tga_rle_pixel_decoder_top tgard_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
